// ===== hw/rtl/cblc_pkg.sv =====
package cblc_pkg;

  localparam int NUM_ENTRIES_DEF = 16;
  localparam int REF_BITS_DEF    = 8;
  localparam int CFG_IDX_W       = 1;
  localparam int CFG_DATA_W      = 32;

  localparam logic [CFG_IDX_W-1:0] REG_SPC = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FDS = 1'd1;

  typedef enum logic [1:0] {
    OP_GET     = 2'd0,
    OP_RELEASE = 2'd1,
    OP_DIRTY   = 2'd2,
    OP_FLUSH   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_FILLED = 3'd1,
    ST_NOBUF  = 3'd2,
    ST_RDERR  = 3'd3,
    ST_WRERR  = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOK,
    S_ACT,
    S_SECT,
    S_FLUSH,
    S_OUT
  } state_t;

  // position-chain command, the same to every cell
  typedef enum logic [1:0] {
    CH_HOLD  = 2'd0,
    CH_FRONT = 2'd1,
    CH_BACK  = 2'd2
  } chain_cmd_t;

  typedef struct packed {
    chain_cmd_t cmd;
    logic [5:0] ent;
  } chain_ctl_t;

  typedef struct packed {
    logic [1:0] op;
    logic [27:0] cluster;
    logic write_only;
    logic [3:0] entry_index;
    logic critical;
    logic writeback_ok;
    logic fill_ok;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  entry_out;
    logic        writeback_req;
    logic [31:0] writeback_sector;
    logic        fill_req;
    logic [31:0] fill_sector;
    logic        last;
  } rsp_t;

endpackage

// ===== hw/rtl/cblc_stream_if.sv =====
interface cblc_stream_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/cluster_buffer_lru_cache.sv =====
// channel  dir  word                                  handshake
// req      in   op,cluster,write_only,entry_index,... valid/ready
// rsp      out  status,entry_out,wb/fill req+sector  valid/ready
// cfg      in   cfg_we, cfg_idx, cfg_data             write enable only
// get/release/dirty: the result passes through lookup, action, sector multiply,
// then sector add into the output register; the next word is taken after that.
// flush: scans positions front first; each dirty word found goes through the same sector steps.
// rst is synchronous; state and chain return to power-up order.
// A stalled result holds in the output register; the next result waits.
module cluster_buffer_lru_cache
  import cblc_pkg::*;
#(
  parameter int NUM_ENTRIES = NUM_ENTRIES_DEF,
  parameter int REF_BITS    = REF_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  cblc_stream_if.sink           req,
  cblc_stream_if.source         rsp
);
  localparam int EW = $clog2(NUM_ENTRIES);
  localparam logic [REF_BITS-1:0] REF_MAX = '1;

  logic [7:0]  spc;
  logic [31:0] fds;
  always_ff @(posedge clk) begin
    if (rst) begin
      spc <= 8'd1;
      fds <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_SPC: spc <= cfg_data[7:0];
        REG_FDS: fds <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [NUM_ENTRIES-1:0] valid_q, dirty_q;
  logic [27:0]            tag_q [NUM_ENTRIES];
  logic [REF_BITS-1:0]    refs_q [NUM_ENTRIES];

  chain_ctl_t ctl;
  logic [EW-1:0] pos [NUM_ENTRIES];
  logic [NUM_ENTRIES:0] hc;

  state_t state, state_next;
  req_t   rq;
  logic   hit_r, inv_r, free_r;
  logic [EW-1:0] hit_er, vic_r;
  logic [EW-1:0] fp;
  rsp_t   rb, rb_next;
  rsp_t   ob, ob_next;
  logic   ovalid;
  logic [27:0] mclus;
  logic [31:0] wprod, fprod;
  logic   fl_hit, fl_more;
  logic [EW-1:0] fl_e;
  logic [EW-1:0] ix;
  logic   idx_ok;

  assign hc[0] = 1'b0;

  for (genvar p = 0; p < NUM_ENTRIES; p++) begin : g_chain
    cblc_cell #(.EW(EW), .INIT(EW'(p))) u_cell (
      .clk, .rst, .ctl, .hit_in(hc[p]),
      .from_prev(pos[(p == 0) ? 0 : p-1]),
      .from_next(pos[(p == NUM_ENTRIES-1) ? p : p+1]),
      .is_front(p == 0), .is_back(p == NUM_ENTRIES-1),
      .ent(pos[p]), .hit_out(hc[p+1]));
  end

  // lookup over positions, one parallel pass
  logic          hit_f, inv_f, free_f;
  logic [EW-1:0] hit_e, inv_e, free_e;
  always_comb begin
    hit_f = 1'b0; inv_f = 1'b0; free_f = 1'b0;
    hit_e = '0; inv_e = '0; free_e = '0;
    for (int p = NUM_ENTRIES-1; p >= 0; p--) begin
      if (valid_q[pos[p]] && tag_q[pos[p]] == rq.cluster) begin
        hit_f = 1'b1; hit_e = pos[p];
      end
    end
    for (int p = 0; p < NUM_ENTRIES; p++) begin
      if (!valid_q[pos[p]]) begin
        inv_f = 1'b1; inv_e = pos[p];
      end
      if (refs_q[pos[p]] == '0) begin
        free_f = 1'b1; free_e = pos[p];
      end
    end
  end

  assign ix     = EW'(rq.entry_index);
  assign idx_ok = int'(rq.entry_index) < NUM_ENTRIES;
  assign fl_e   = pos[fp];
  assign fl_hit = valid_q[fl_e] && dirty_q[fl_e];
  assign req.ready  = (state == S_IDLE);
  assign rsp.valid  = ovalid;
  assign rsp.data   = ob;

  // any dirty word left behind the flush pointer
  always_comb begin
    fl_more = 1'b0;
    for (int p = 0; p < NUM_ENTRIES; p++) begin
      if (p > int'(fp) && valid_q[pos[p]] && dirty_q[pos[p]]) fl_more = 1'b1;
    end
  end

  always_comb begin
    rb_next = '0;
    rb_next.last = 1'b1;
    if (state == S_FLUSH) begin
      if (fl_hit) begin
        rb_next.status = rq.writeback_ok ? ST_OK : ST_WRERR;
        rb_next.entry_out = 4'(fl_e);
        rb_next.writeback_req = 1'b1;
        rb_next.last = !fl_more;
      end
    end else if (rq.op == OP_GET) begin
      if (hit_r) begin
        rb_next.entry_out = 4'(hit_er);
      end else if (!inv_r && !free_r) begin
        rb_next.status = ST_NOBUF;
      end else begin
        rb_next.entry_out = 4'(vic_r);
        rb_next.writeback_req = !inv_r && dirty_q[vic_r];
        if (rb_next.writeback_req && !rq.writeback_ok) begin
          rb_next.status = ST_WRERR;
        end else begin
          rb_next.fill_req = !rq.write_only;
          rb_next.status = (!rq.write_only && !rq.fill_ok) ? ST_RDERR : ST_FILLED;
        end
      end
    end else begin
      rb_next.entry_out = rq.entry_index;
    end
  end

  always_comb begin
    ob_next = rb;
    ob_next.writeback_sector = rb.writeback_req ? fds + wprod : '0;
    ob_next.fill_sector      = rb.fill_req ? fds + fprod : '0;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (req.valid) state_next = S_LOOK;
      S_LOOK: state_next = (rq.op == OP_FLUSH) ? S_FLUSH : S_ACT;
      S_ACT:  state_next = S_SECT;
      S_SECT: state_next = S_OUT;
      S_FLUSH: begin
        if (fl_hit || fp == EW'(NUM_ENTRIES-1)) state_next = S_SECT;
      end
      S_OUT: begin
        if (!ovalid || rsp.ready) begin
          state_next = (rq.op == OP_FLUSH && !rb.last) ? S_FLUSH : S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    ctl.cmd = CH_HOLD;
    ctl.ent = '0;
    if (state == S_ACT && rq.op == OP_GET) begin
      if (hit_r) begin
        ctl.cmd = CH_FRONT; ctl.ent = 6'(hit_er);
      end else if (rb_next.status == ST_FILLED) begin
        ctl.cmd = CH_FRONT; ctl.ent = 6'(vic_r);
      end
    end else if (state == S_ACT && rq.op == OP_RELEASE && idx_ok
                 && refs_q[ix] == REF_BITS'(1) && !rq.critical) begin
      ctl.cmd = CH_BACK; ctl.ent = 6'(ix);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      valid_q <= '0;
      dirty_q <= '0;
      ovalid  <= 1'b0;
      for (int i = 0; i < NUM_ENTRIES; i++) refs_q[i] <= '0;
    end else begin
      state <= state_next;
      if (state == S_OUT && (!ovalid || rsp.ready)) ovalid <= 1'b1;
      else if (rsp.ready) ovalid <= 1'b0;
      case (state)
        S_IDLE: if (req.valid) begin
          rq <= req.data;
          fp <= '0;
        end
        S_LOOK: begin
          hit_r <= hit_f; hit_er <= hit_e;
          inv_r <= inv_f; free_r <= free_f;
          vic_r <= inv_f ? inv_e : free_e;
        end
        S_ACT: begin
          rb <= rb_next;
          mclus <= tag_q[vic_r];
          if (rq.op == OP_GET) begin
            if (hit_r) begin
              if (refs_q[hit_er] != REF_MAX) refs_q[hit_er] <= refs_q[hit_er] + 1'b1;
            end else if ((inv_r || free_r) && rb_next.status != ST_WRERR) begin
              dirty_q[vic_r] <= 1'b0;
              tag_q[vic_r] <= rq.cluster;
              if (rb_next.status == ST_RDERR) begin
                valid_q[vic_r] <= 1'b0;
                refs_q[vic_r] <= '0;
              end else begin
                valid_q[vic_r] <= 1'b1;
                refs_q[vic_r] <= REF_BITS'(1);
              end
            end
          end else if (idx_ok && refs_q[ix] != '0) begin
            if (rq.op == OP_RELEASE) refs_q[ix] <= refs_q[ix] - 1'b1;
            else dirty_q[ix] <= 1'b1;
          end
        end
        S_FLUSH: begin
          if (fl_hit || fp == EW'(NUM_ENTRIES-1)) rb <= rb_next;
          if (fl_hit) begin
            mclus <= tag_q[fl_e];
            dirty_q[fl_e] <= 1'b0;
          end
          fp <= fp + 1'b1;
        end
        S_SECT: begin
          wprod <= (32'(mclus) - 32'd2) * {24'd0, spc};
          fprod <= (32'(rq.cluster) - 32'd2) * {24'd0, spc};
        end
        S_OUT: if (!ovalid || rsp.ready) begin
          ob <= ob_next;
        end
        default: ;
      endcase
    end
  end
endmodule

// ===== hw/rtl/cblc_cell.sv =====
// one recency position: holds an entry number, shifts toward front or back
module cblc_cell
  import cblc_pkg::*;
#(
  parameter int EW = 4,
  parameter logic [EW-1:0] INIT = '0
) (
  input  logic          clk,
  input  logic          rst,
  input  chain_ctl_t    ctl,
  input  logic          hit_in,
  input  logic [EW-1:0] from_prev,
  input  logic [EW-1:0] from_next,
  input  logic          is_front,
  input  logic          is_back,
  output logic [EW-1:0] ent,
  output logic          hit_out
);
  logic match;
  assign match   = (ent == ctl.ent[EW-1:0]);
  assign hit_out = hit_in | match;

  always_ff @(posedge clk) begin
    if (rst) begin
      ent <= INIT;
    end else begin
      case (ctl.cmd)
        CH_FRONT: begin
          if (is_front) ent <= ctl.ent[EW-1:0];
          else if (!hit_in) ent <= from_prev;
        end
        CH_BACK: begin
          if (is_back) begin
            if (hit_in | match) ent <= ctl.ent[EW-1:0];
          end else if (hit_in | match) ent <= from_next;
        end
        default: ;
      endcase
    end
  end
endmodule

// ===== tb/cluster_buffer_lru_cache_tb.sv =====
`timescale 1ns / 100ps

module cluster_buffer_lru_cache_tb;
  import cblc_pkg::*;

  localparam int N_ENT   = 16;
  localparam int REF_MAX = 255;
  localparam int LIMIT   = 600000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  cblc_stream_if #(.T(req_t)) req ();
  cblc_stream_if #(.T(rsp_t)) rsp ();

  cluster_buffer_lru_cache i_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
    .req(req), .rsp(rsp)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // cache model
  logic [7:0]  m_spc;
  logic [31:0] m_fds;
  logic        m_valid [N_ENT];
  logic [27:0] m_tag   [N_ENT];
  logic        m_dirty [N_ENT];
  int          m_refs  [N_ENT];
  int          m_order [N_ENT];

  req_t pending_words[$];
  rsp_t expected_words[$];
  int   send_idle_pct = 12;
  int   recv_idle_pct = 51;
  int   cycles = 0;
  bit   failed = 0;
  bit   req_acc = 0;

  function automatic logic [31:0] sector_of(logic [27:0] c);
    return m_fds + (32'(c) - 32'd2) * 32'(m_spc);
  endfunction

  function automatic int pos_of(int e);
    for (int p = 0; p < N_ENT; p++) if (m_order[p] == e) return p;
    return 0;
  endfunction

  function automatic void move_front(int e);
    int p;
    p = pos_of(e);
    for (int k = p; k > 0; k--) m_order[k] = m_order[k-1];
    m_order[0] = e;
  endfunction

  function automatic void move_back(int e);
    int p;
    p = pos_of(e);
    for (int k = p; k < N_ENT-1; k++) m_order[k] = m_order[k+1];
    m_order[N_ENT-1] = e;
  endfunction

  function automatic rsp_t mk(status_t st, int ent, bit wr, logic [31:0] ws, bit fr,
                              logic [31:0] fs, bit lst);
    rsp_t r;
    r.status = st; r.entry_out = ent[3:0]; r.writeback_req = wr;
    r.writeback_sector = ws; r.fill_req = fr; r.fill_sector = fs; r.last = lst;
    return r;
  endfunction

  function automatic void predict_get(req_t w);
    int e, c;
    bit found;
    bit wr;
    logic [31:0] ws, fs;
    found = 0; wr = 0; ws = '0; e = 0;
    for (int p = 0; p < N_ENT; p++) begin
      c = m_order[p];
      if (m_valid[c] && m_tag[c] == w.cluster) begin
        move_front(c);
        if (m_refs[c] < REF_MAX) m_refs[c]++;
        expected_words.push_back(mk(ST_OK, c, 0, 0, 0, 0, 1));
        return;
      end
    end
    for (int p = N_ENT-1; p >= 0 && !found; p--)
      if (!m_valid[m_order[p]]) begin e = m_order[p]; found = 1; end
    if (!found) begin
      for (int p = N_ENT-1; p >= 0 && !found; p--)
        if (m_refs[m_order[p]] == 0) begin e = m_order[p]; found = 1; end
      if (!found) begin
        expected_words.push_back(mk(ST_NOBUF, 0, 0, 0, 0, 0, 1));
        return;
      end
      if (m_dirty[e]) begin
        wr = 1; ws = sector_of(m_tag[e]);
        if (!w.writeback_ok) begin
          expected_words.push_back(mk(ST_WRERR, e, wr, ws, 0, 0, 1));
          return;
        end
      end
    end
    m_refs[e] = 1; m_tag[e] = w.cluster; m_valid[e] = 1; m_dirty[e] = 0;
    if (!w.write_only) begin
      fs = sector_of(w.cluster);
      if (!w.fill_ok) begin
        m_refs[e] = 0; m_valid[e] = 0;
        expected_words.push_back(mk(ST_RDERR, e, wr, ws, 1, fs, 1));
        return;
      end
      move_front(e);
      expected_words.push_back(mk(ST_FILLED, e, wr, ws, 1, fs, 1));
      return;
    end
    move_front(e);
    expected_words.push_back(mk(ST_FILLED, e, wr, ws, 0, 0, 1));
  endfunction

  function automatic void predict_word(req_t w);
    int n, c;
    rsp_t r;
    n = 0;
    case (op_t'(w.op))
      OP_GET: predict_get(w);
      OP_FLUSH: begin
        for (int p = 0; p < N_ENT; p++) begin
          c = m_order[p];
          if (m_valid[c] && m_dirty[c]) begin
            expected_words.push_back(mk(w.writeback_ok ? ST_OK : ST_WRERR, c, 1,
                                        sector_of(m_tag[c]), 0, 0, 0));
            m_dirty[c] = 0;
            n++;
          end
        end
        if (n == 0) expected_words.push_back(mk(ST_OK, 0, 0, 0, 0, 0, 1));
        else begin
          r = expected_words.pop_back();
          r.last = 1;
          expected_words.push_back(r);
        end
      end
      default: begin
        if (m_refs[w.entry_index] > 0) begin
          if (op_t'(w.op) == OP_RELEASE) begin
            m_refs[w.entry_index]--;
            if (m_refs[w.entry_index] == 0 && !w.critical) move_back(w.entry_index);
          end else m_dirty[w.entry_index] = 1;
        end
        expected_words.push_back(mk(ST_OK, w.entry_index, 0, 0, 0, 0, 1));
      end
    endcase
  endfunction

  // driver
  initial begin
    req.valid = 1'b0;
    req.data = '0;
  end

  always @(negedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
    end else if (req.valid && !req_acc) begin
    end else if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
      req.valid <= 1'b1;
      req.data <= pending_words.pop_front();
    end else begin
      req.valid <= 1'b0;
    end
  end

  always @(negedge clk) begin
    rsp.ready <= !rst && ($urandom_range(99) >= recv_idle_pct);
  end

  // monitor
  always @(posedge clk) begin
    rsp_t e;
    cycles <= cycles + 1;
    req_acc <= !rst && req.valid && req.ready;
    if (!rst && req.valid && req.ready) predict_word(req.data);
    if (!rst && rsp.valid && rsp.ready) begin
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected word %p", $time, rsp.data);
        failed = 1;
      end else begin
        e = expected_words.pop_front();
        if (rsp.data.status !== e.status || rsp.data.entry_out !== e.entry_out ||
            rsp.data.writeback_req !== e.writeback_req ||
            rsp.data.writeback_sector !== e.writeback_sector ||
            rsp.data.fill_req !== e.fill_req || rsp.data.fill_sector !== e.fill_sector ||
            rsp.data.last !== e.last) begin
          $display("%0t: mismatch expected %p actual %p", $time, e, rsp.data);
          failed = 1;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic req_t mkreq(op_t op, logic [27:0] cl, bit wo, int idx, bit cr,
                                 bit wok, bit fok);
    req_t w;
    w.op = op; w.cluster = cl; w.write_only = wo; w.entry_index = idx[3:0];
    w.critical = cr; w.writeback_ok = wok; w.fill_ok = fok;
    return w;
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1'b1; cfg_idx <= idx; cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_SPC) m_spc = val[7:0];
    else m_fds = val;
  endtask

  task automatic drain();
    while (pending_words.size() > 0 || req.valid || expected_words.size() > 0)
      @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  function automatic logic [27:0] pick_cluster(int pool);
    logic [27:0] c;
    if (pool == 0) c = 28'($urandom_range(31, 2));
    else c = 28'($urandom_range(32'h0FFF_FFFF, 2));
    return c;
  endfunction

  // random content; get-heavy with releases to keep entries free
  task automatic random_phase(int count, int pool);
    int k;
    req_t w;
    logic [63:0] rnd;
    for (int i = 0; i < count; i++) begin
      k = $urandom_range(99);
      rnd = {$urandom, $urandom};
      w = rnd[$bits(req_t)-1:0];
      if (k < 50) begin
        w.op = OP_GET;
        w.cluster = pick_cluster(pool);
      end else if (k < 75) w.op = OP_RELEASE;
      else if (k < 92) w.op = OP_DIRTY;
      else w.op = OP_FLUSH;
      if (w.op == OP_GET && $urandom_range(3) != 0) begin
        w.writeback_ok = 1; w.fill_ok = 1;
      end
      pending_words.push_back(w);
    end
  endtask

  initial begin
    m_spc = 8'd1; m_fds = '0;
    for (int i = 0; i < N_ENT; i++) begin
      m_valid[i] = 0; m_tag[i] = '0; m_dirty[i] = 0; m_refs[i] = 0; m_order[i] = i;
    end
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    write_reg(REG_SPC, 32'd128);
    write_reg(REG_FDS, 32'hFFFF_FFF0);
    // directed: fill all entries, overflow, errors, flush
    for (int i = 0; i < 16; i++)
      pending_words.push_back(mkreq(OP_GET, 28'(i + 2), i[0], 0, 0, 1, 1));
    pending_words.push_back(mkreq(OP_GET, 28'h0FFF_FFFF, 0, 0, 0, 1, 1));
    pending_words.push_back(mkreq(OP_DIRTY, '0, 0, 3, 0, 1, 1));
    pending_words.push_back(mkreq(OP_RELEASE, '0, 0, 3, 1, 1, 1));
    pending_words.push_back(mkreq(OP_GET, 28'h0FFF_FFFF, 0, 0, 0, 0, 1));
    pending_words.push_back(mkreq(OP_GET, 28'h0FFF_FFFF, 0, 0, 0, 1, 0));
    pending_words.push_back(mkreq(OP_RELEASE, '0, 0, 15, 0, 1, 1));
    pending_words.push_back(mkreq(OP_RELEASE, '0, 0, 3, 0, 1, 1));
    pending_words.push_back(mkreq(OP_DIRTY, '0, 0, 5, 0, 1, 1));
    pending_words.push_back(mkreq(OP_FLUSH, '0, 0, 0, 0, 0, 1));
    pending_words.push_back(mkreq(OP_FLUSH, '0, 0, 0, 0, 1, 1));
    drain();

    // saturation: hit one cluster past the count limit
    for (int i = 0; i < 258; i++)
      pending_words.push_back(mkreq(OP_GET, 28'd5, 0, 0, 0, 1, 1));
    drain();

    write_reg(REG_SPC, 32'd1);
    write_reg(REG_FDS, 32'd0);
    random_phase(58, 0);
    drain();

    send_idle_pct = 51; recv_idle_pct = 12;
    write_reg(REG_SPC, 32'($urandom_range(128, 1)));
    write_reg(REG_FDS, $urandom);
    random_phase(58, 1);
    drain();

    send_idle_pct = 0; recv_idle_pct = 0;
    write_reg(REG_SPC, 32'd64);
    write_reg(REG_FDS, 32'hFFFF_FFFF);
    random_phase(60, 0);
    drain();

    if (!failed) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
